### src/gmt_pkg.sv
// Package: shared types, register indexes and record codes for the gyro mouse core.
package gmt_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_ENABLE        = 3'd0;
    localparam logic [2:0] REG_BIAS_X        = 3'd1;
    localparam logic [2:0] REG_BIAS_Y        = 3'd2;
    localparam logic [2:0] REG_DEADZONE      = 3'd3;
    localparam logic [2:0] REG_GAIN          = 3'd4;
    localparam logic [2:0] REG_INVERT_MASK   = 3'd5;
    localparam logic [2:0] REG_TAP_THRESHOLD = 3'd6;
    localparam logic [2:0] REG_TAP_COOLDOWN  = 3'd7;

    // Record kinds
    localparam logic [1:0] AXIS_X     = 2'd0;
    localparam logic [1:0] AXIS_Y     = 2'd1;
    localparam logic [1:0] AXIS_CLICK = 2'd2;

    localparam int JOB_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    typedef struct packed {
        logic signed [15:0] rate_a;
        logic signed [15:0] rate_b;
        logic signed [15:0] accel_sample;
    } sample_t;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [15:0] amount;
        logic               last;
    } record_t;

    typedef struct packed {
        logic               enable;
        logic signed [15:0] bias_x;
        logic signed [15:0] bias_y;
        logic [15:0]        deadzone;
        logic [15:0]        gain;
        logic [1:0]         invert_mask;
        logic [15:0]        tap_threshold;
        logic [15:0]        tap_cooldown;
    } cfg_t;

    // One classified sample waiting for the back end
    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic               click;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_wr_t;

    typedef struct packed {
        logic    valid;
        record_t rec;
    } rec_wr_t;

    typedef enum logic [1:0] {
        PH_X,
        PH_Y,
        PH_CLICK
    } phase_t;

endpackage

### src/gmt_front.sv
// Front end: tap detection state, bias subtraction and job generation per sample.
module gmt_front
    import gmt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  sample_t sample,
    input  cfg_t    cfg,
    output job_wr_t job_wr
);

    logic signed [15:0] prev_accel_reg, prev_accel_next;
    logic [15:0]        since_tap_reg, since_tap_next;
    logic [15:0]        since_inc;
    logic signed [16:0] rise;
    logic               click;

    always_comb
    begin
        since_inc = (since_tap_reg == 16'hFFFF) ? since_tap_reg : since_tap_reg + 16'd1;
        rise      = {sample.accel_sample[15], sample.accel_sample}
                  - {prev_accel_reg[15], prev_accel_reg};
        click     = cfg.enable && (rise > $signed({1'b0, cfg.tap_threshold}))
                  && (since_inc > cfg.tap_cooldown);

        since_tap_next  = since_tap_reg;
        prev_accel_next = prev_accel_reg;
        if (accept)
        begin
            since_tap_next = click ? 16'd0 : since_inc;
            if (cfg.enable)
                prev_accel_next = sample.accel_sample;
        end

        job_wr.valid     = accept && cfg.enable;
        job_wr.job.dx    = {sample.rate_a[15], sample.rate_a} - {cfg.bias_x[15], cfg.bias_x};
        job_wr.job.dy    = {sample.rate_b[15], sample.rate_b} - {cfg.bias_y[15], cfg.bias_y};
        job_wr.job.click = click;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_accel_reg <= '0;
            since_tap_reg  <= 16'hFFFF;
        end
        else
        begin
            prev_accel_reg <= prev_accel_next;
            since_tap_reg  <= since_tap_next;
        end
    end

endmodule

### src/gmt_job_q.sv
// Job queue: two-entry queue between front end and back end.
module gmt_job_q
    import gmt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  job_wr_t job_wr,
    input  logic    rd,
    output job_t    job,
    output logic    job_valid,
    output logic    full
);

    localparam int PW = $clog2(JOB_DEPTH);

    job_t            mem [JOB_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg, count_next;
    logic            do_wr, do_rd;

    assign do_wr     = job_wr.valid;
    assign do_rd     = rd && job_valid;
    assign job_valid = (count_reg != '0);
    assign full      = (count_reg == (PW+1)'(JOB_DEPTH));
    assign job       = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= job_wr.job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

### src/gmt_back.sv
// Back end: record sequencer and two-stage scale pipeline feeding the result queue.
module gmt_back
    import gmt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  job_t                       job,
    input  logic                       job_valid,
    output logic                       job_rd,
    input  logic [$clog2(RES_DEPTH):0] res_level,
    output rec_wr_t                    rec_wr
);

    localparam int LW = $clog2(RES_DEPTH) + 1;

    phase_t             phase_reg, phase_next;
    logic               issue;
    logic [LW-1:0]      used;
    logic [1:0]         iss_axis;
    logic               iss_last;
    logic signed [16:0] iss_d;
    logic               iss_inv;
    logic [15:0]        iss_abs;

    logic               s1_valid_reg;
    logic [1:0]         s1_axis_reg;
    logic               s1_last_reg;
    logic               s1_neg_reg;
    logic               s1_zero_reg;
    logic [15:0]        s1_mag_reg;

    logic               s2_valid_reg;
    logic [1:0]         s2_axis_reg;
    logic               s2_last_reg;
    logic               s2_neg_reg;
    logic               s2_zero_reg;
    logic [15:0]        s2_prod_reg;
    logic [31:0]        prod;
    logic [15:0]        neg_val;

    // Issue only when the result queue has room for everything in flight
    assign used  = res_level + LW'(s1_valid_reg) + LW'(s2_valid_reg);
    assign issue = job_valid && (used < LW'(RES_DEPTH));

    always_comb
    begin
        phase_next = phase_reg;
        if (issue)
        begin
            unique case (phase_reg)
                PH_X:     phase_next = PH_Y;
                PH_Y:     phase_next = job.click ? PH_CLICK : PH_X;
                PH_CLICK: phase_next = PH_X;
                default:  phase_next = PH_X;
            endcase
        end
    end

    always_comb
    begin
        iss_axis = AXIS_X;
        iss_last = 1'b0;
        iss_d    = job.dx;
        iss_inv  = cfg.invert_mask[0];
        job_rd   = 1'b0;
        unique case (phase_reg)
            PH_X:
            begin
                iss_axis = AXIS_X;
            end
            PH_Y:
            begin
                iss_axis = AXIS_Y;
                iss_d    = job.dy;
                iss_inv  = cfg.invert_mask[1];
                iss_last = !job.click;
                job_rd   = issue && !job.click;
            end
            PH_CLICK:
            begin
                iss_axis = AXIS_CLICK;
                iss_last = 1'b1;
                job_rd   = issue;
            end
            default:
            begin
                iss_axis = AXIS_X;
            end
        endcase
        // |d| never exceeds 65535, so the magnitude fits 16 bits
        iss_abs = iss_d[16] ? 16'(-iss_d) : 16'(iss_d);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_X;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage 1: magnitude, deadzone and output sign
    always_ff @(posedge clk)
    begin
        s1_axis_reg <= iss_axis;
        s1_last_reg <= iss_last;
        s1_neg_reg  <= iss_d[16] ^ iss_inv;
        s1_mag_reg  <= iss_abs;
        s1_zero_reg <= (iss_abs < cfg.deadzone);
    end

    // Stage 2: Q16 gain, keep the integer part
    assign prod = s1_mag_reg * cfg.gain;

    always_ff @(posedge clk)
    begin
        s2_axis_reg <= s1_axis_reg;
        s2_last_reg <= s1_last_reg;
        s2_neg_reg  <= s1_neg_reg;
        s2_zero_reg <= s1_zero_reg;
        s2_prod_reg <= prod[31:16];
    end

    // Output: click records carry 1, deadzone gives 0, else restore sign and clamp to int16
    assign neg_val = ~s2_prod_reg + 16'd1;

    always_comb
    begin
        rec_wr.valid    = s2_valid_reg;
        rec_wr.rec.axis = s2_axis_reg;
        rec_wr.rec.last = s2_last_reg;
        priority if (s2_axis_reg == AXIS_CLICK)
            rec_wr.rec.amount = 16'sd1;
        else if (s2_zero_reg)
            rec_wr.rec.amount = '0;
        else if (s2_neg_reg)
            rec_wr.rec.amount = (s2_prod_reg > 16'd32768) ? 16'sh8000 : $signed(neg_val);
        else
            rec_wr.rec.amount = (s2_prod_reg > 16'd32767) ? 16'sh7FFF : $signed(s2_prod_reg);
    end

endmodule

### src/gmt_res_fifo.sv
// Result queue: holds finished records until the consumer pops them.
module gmt_res_fifo
    import gmt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  rec_wr_t                    rec_wr,
    input  logic                       pop,
    output record_t                    record,
    output logic                       empty,
    output logic [$clog2(RES_DEPTH):0] level
);

    localparam int PW = $clog2(RES_DEPTH);

    record_t       mem [RES_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg, count_next;
    logic          do_rd;

    assign empty  = (count_reg == '0);
    assign do_rd  = pop && !empty;
    assign record = mem[rd_ptr_reg];
    assign level  = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (rec_wr.valid && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !rec_wr.valid)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (rec_wr.valid)
            mem[wr_ptr_reg] <= rec_wr.rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (rec_wr.valid)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

### src/gyro_mouse_motion_and_tap_core.sv
// Top level: gyro mouse motion and tap record generator with configuration registers.
//
//  channel   handshake                 payload
//  -------   ------------------------  -------------------------------------
//  samples   push in / full out        sample : rate_a, rate_b, accel_sample
//  records   pop in / empty out        record : axis, amount, last
//  config    cfg_valid / cfg_ready     cfg_index (3 b), cfg_data (16 b)
//
//  An enabled sample yields two records (X, Y) or three (X, Y, click); the
//  record sequencer issues one record per cycle into the scale pipeline while
//  a job waits and the result queue has room. The first record passes the job
//  queue, the stage 1 and stage 2 registers and the result queue before popping.
//  A disabled sample only advances the tap counter.
//  Reset (rst_n low, asynchronous) empties both queues and loads register
//  defaults; cfg_ready is always high. Stalls on pop back up through the
//  result queue into the job queue, and full rises once two jobs wait.
module gyro_mouse_motion_and_tap_core
    import gmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  sample_t     sample,
    input  logic        pop,
    output logic        empty,
    output record_t     record,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t                       cfg_reg, cfg_next;
    logic                       accept;
    job_wr_t                    job_wr;
    job_t                       job;
    logic                       job_valid;
    logic                       job_rd;
    rec_wr_t                    rec_wr;
    logic [$clog2(RES_DEPTH):0] res_level;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    // Register file: decode index, hold everything else
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ENABLE:        cfg_next.enable        = cfg_data[0];
                REG_BIAS_X:        cfg_next.bias_x        = $signed(cfg_data);
                REG_BIAS_Y:        cfg_next.bias_y        = $signed(cfg_data);
                REG_DEADZONE:      cfg_next.deadzone      = cfg_data;
                REG_GAIN:          cfg_next.gain          = cfg_data;
                REG_INVERT_MASK:   cfg_next.invert_mask   = cfg_data[1:0];
                REG_TAP_THRESHOLD: cfg_next.tap_threshold = cfg_data;
                REG_TAP_COOLDOWN:  cfg_next.tap_cooldown  = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= 1'b1;
            cfg_reg.bias_x        <= '0;
            cfg_reg.bias_y        <= '0;
            cfg_reg.deadzone      <= 16'd524;
            cfg_reg.gain          <= 16'd1251;
            cfg_reg.invert_mask   <= 2'd2;
            cfg_reg.tap_threshold <= 16'd9830;
            cfg_reg.tap_cooldown  <= 16'd30;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: classify the sample, advance tap state
    gmt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (sample),
        .cfg    (cfg_reg),
        .job_wr (job_wr)
    );

    // Decouple classification from record generation
    gmt_job_q u_job_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_wr    (job_wr),
        .rd        (job_rd),
        .job       (job),
        .job_valid (job_valid),
        .full      (full)
    );

    // Back end: sequence records through the scale pipeline
    gmt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job       (job),
        .job_valid (job_valid),
        .job_rd    (job_rd),
        .res_level (res_level),
        .rec_wr    (rec_wr)
    );

    gmt_res_fifo u_res_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .rec_wr (rec_wr),
        .pop    (pop),
        .record (record),
        .empty  (empty),
        .level  (res_level)
    );

    // The credit check must keep the result queue from overflowing
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        rec_wr.valid |-> (res_level < ($clog2(RES_DEPTH)+1)'(RES_DEPTH)) || (pop && !empty))
        else $error("result queue overflow");

    // A click record closes its sample and carries amount 1
    a_click_record: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && record.axis == AXIS_CLICK) |-> (record.last && record.amount == 16'sd1))
        else $error("malformed click record");

    // A horizontal record never ends a sample
    a_x_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && record.axis == AXIS_X) |-> !record.last)
        else $error("horizontal record marked last");

    // A job is only released while one is waiting
    a_job_release: assert property (@(posedge clk) disable iff (!rst_n)
        job_rd |-> job_valid)
        else $error("job released while queue empty");

endmodule
